@@ sv/segment_map_translator_top_macros.svh @@
// Assertion macros for the segment map translator.
// Used by segment_map_translator_top; needs a clk and an arst_n in scope.
`ifndef SEGMENT_MAP_TRANSLATOR_TOP_MACROS_SVH
`define SEGMENT_MAP_TRANSLATOR_TOP_MACROS_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define SMT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("segment map translator check failed");
// The consequent must hold in the cycle after the antecedent.
`define SMT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("segment map translator check failed");
`else
`define SMT_ASSERT_NOW(lbl, ante, cons)
`define SMT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/smt_pkg.sv @@
// Shared types and codes for the segment map translator.
// No dependencies; imported by smt_cell, segment_map_translator_top and the testbench.
package smt_pkg;

	localparam logic [2:0] OP_APPEND  = 3'd0;
	localparam logic [2:0] OP_REMOVE  = 3'd1;
	localparam logic [2:0] OP_LOOKUP  = 3'd2;
	localparam logic [2:0] OP_NEAREST = 3'd3;
	localparam logic [2:0] OP_SPLIT   = 3'd4;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NOT_MAP = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_ZERO_WR = 3'd3;
	localparam logic [2:0] ST_IGNORED = 3'd4;

	localparam logic [1:0] KIND_FILE  = 2'd0;
	localparam logic [1:0] KIND_ZERO  = 2'd2;
	localparam logic [1:0] KIND_RSVD  = 2'd3;

	typedef struct packed {
		logic [63:0] base;
		logic [63:0] size;
		logic [63:0] backing;
		logic [1:0]  kind;
	} seg_entry_t;

	typedef struct packed {
		logic        vld;
		logic        near;
		logic [63:0] addr;
		logic        found;
		logic [63:0] gap;
		seg_entry_t  ent;
	} search_tok_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LAUNCH,
		S_WAIT,
		S_CALC,
		S_OUT
	} seq_state_t;

endpackage

@@ sv/segment_map_translator_top.sv @@
// Top level of the segment map translator: sequencer, output register and the cell chain.
// Depends on smt_pkg, smt_cell and segment_map_translator_top_macros.svh.
//
// The block keeps an ordered table of up to MAX_SEGMENTS segments in a row of cells, one
// entry per cell. Append and remove are done in the cycle the item is accepted (remove
// shifts every entry above the gap down by one cell at once) and give their single result
// through the result registers and the output register. A lookup, a nearest-above search
// and every piece of a non-empty split transfer send a search token through the whole row,
// one cell per clock. Each search goes through these steps: launch, the walk through the
// chain, working out the offset, the clipped length and loading the output register; a
// split transfer repeats them for each piece. One item is handled at a time; the block takes
// the next item as soon as the last result of the current one sits in the output register,
// and a stalled output holds the sequencer only when it has a further result to hand over.
`include "segment_map_translator_top_macros.svh"
module segment_map_translator_top import smt_pkg::*; #(
	parameter int MAX_SEGMENTS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// address[63:0], length[95:64], is_write[96], entry_base[160:97],
	// entry_size[224:161], entry_backing_offset[288:225], entry_kind[290:289],
	// entry_index[294:291], zero pad[295]
	input  logic [295:0] s_tdata,
	// operation[2:0]
	input  logic [2:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// index[3:0], hit_base[67:4], hit_size[131:68], hit_backing_offset[195:132],
	// hit_kind[197:196], piece_offset[261:198], piece_length[293:262],
	// entries_used[298:294], zero pad[303:299]
	output logic [303:0] m_tdata,
	// status[2:0]
	output logic [2:0]   m_tuser,
	// last
	output logic         m_tlast
);

	localparam int IW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CW   = $clog2(MAX_SEGMENTS + 1);
	localparam int PW   = $clog2(MAX_SEGMENTS + 2);
	localparam int CMPW = CW + 4;

	// Fields of the incoming item.
	logic [2:0]  in_op;
	logic [63:0] in_addr;
	logic [31:0] in_len;
	logic        in_wr;
	logic [1:0]  in_kind;
	logic [3:0]  in_index;
	seg_entry_t  new_ent;

	assign in_op    = s_tuser;
	assign in_addr  = s_tdata[63:0];
	assign in_len   = s_tdata[95:64];
	assign in_wr    = s_tdata[96];
	assign in_kind  = s_tdata[290:289];
	assign in_index = s_tdata[294:291];

	always_comb begin
		new_ent.base    = s_tdata[160:97];
		new_ent.size    = s_tdata[224:161];
		new_ent.backing = s_tdata[288:225];
		// The reserved kind code is stored as a file segment.
		new_ent.kind    = (in_kind == KIND_RSVD) ? KIND_FILE : in_kind;
	end

	seq_state_t     state_q;
	seq_state_t     state_d;
	logic           launch;
	logic           push;
	logic           in_go;

	logic [CW-1:0]  count_q;
	logic           near_q;
	logic           split_q;
	logic [63:0]    addr_q;
	logic [31:0]    rem_q;
	logic           wr_q;
	logic [PW-1:0]  pieces_q;

	logic           found_q;
	seg_entry_t     hit_q;
	logic [IW-1:0]  hidx_q;
	logic [63:0]    off_q;

	logic [2:0]     res_status_q;
	logic [3:0]     res_idx_q;
	seg_entry_t     res_ent_q;
	logic [63:0]    res_off_q;
	logic [31:0]    res_len_q;
	logic           res_last_q;

	logic           m_tvalid_q;
	logic [303:0]   m_tdata_q;
	logic [2:0]     m_tuser_q;
	logic           m_tlast_q;

	logic           is_app;
	logic           is_rm;
	logic           is_look;
	logic           is_near;
	logic           is_split;
	logic           full;
	logic           rm_ok;
	logic           app_go;
	logic           rm_go;

	logic [63:0]    room;
	logic [31:0]    nn;
	logic           zero_wr;

	search_tok_t    tok_d0;
	search_tok_t    tok_s0;
	search_tok_t    tok_c [MAX_SEGMENTS+1];
	logic [IW-1:0]  idx_c [MAX_SEGMENTS+1];
	seg_entry_t     ent_c [MAX_SEGMENTS];

	assign is_app   = (in_op == OP_APPEND);
	assign is_rm    = (in_op == OP_REMOVE);
	assign is_look  = (in_op == OP_LOOKUP);
	assign is_near  = (in_op == OP_NEAREST);
	assign is_split = (in_op == OP_SPLIT);
	assign full     = (count_q == CW'(MAX_SEGMENTS));
	assign rm_ok    = (CMPW'(in_index) < CMPW'(count_q));
	assign in_go    = s_tvalid && s_tready;
	assign app_go   = in_go && is_app && !full;
	assign rm_go    = in_go && is_rm && rm_ok;

	// Next state of the sequencer.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_go) begin
					if (is_look || is_near || (is_split && in_len != 32'd0)) begin
						state_d = S_LAUNCH;
					end else if (is_app || is_rm || is_split) begin
						state_d = S_OUT;
					end
				end
			end
			S_LAUNCH: state_d = S_WAIT;
			S_WAIT: begin
				if (tok_c[MAX_SEGMENTS].vld) begin
					state_d = S_CALC;
				end
			end
			S_CALC: state_d = S_OUT;
			S_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = res_last_q ? S_IDLE : S_LAUNCH;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		s_tready = 1'b0;
		launch   = 1'b0;
		push     = 1'b0;
		unique case (state_q)
			S_IDLE:   s_tready = 1'b1;
			S_LAUNCH: launch   = 1'b1;
			S_OUT:    push     = !m_tvalid_q || m_tready;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (app_go) begin
				count_q <= count_q + CW'(1);
			end else if (rm_go) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// The clipped length of a piece: the room left in the segment or what remains of the
	// transfer, whichever is smaller.
	always_comb begin
		room    = hit_q.size - off_q;
		nn      = ((room[63:32] == 32'd0) && (room[31:0] < rem_q)) ? room[31:0] : rem_q;
		zero_wr = wr_q && (hit_q.kind == KIND_ZERO);
	end

	always_ff @(posedge clk) begin
		if (in_go) begin
			near_q    <= is_near;
			split_q   <= is_split;
			addr_q    <= in_addr;
			rem_q     <= in_len;
			wr_q      <= in_wr;
			pieces_q  <= '0;
			res_ent_q <= '0;
			res_off_q <= '0;
			res_len_q <= '0;
			res_last_q <= 1'b1;
			if (is_app) begin
				res_status_q <= full ? ST_FULL : ST_OK;
				res_idx_q    <= full ? 4'd0 : 4'(count_q);
			end else if (is_rm) begin
				res_status_q <= rm_ok ? ST_OK : ST_IGNORED;
				res_idx_q    <= in_index;
			end else begin
				// Empty transfer; a search replaces this result once its token returns.
				res_status_q <= ST_OK;
				res_idx_q    <= 4'd0;
			end
		end
		if (state_q == S_WAIT && tok_c[MAX_SEGMENTS].vld) begin
			found_q <= tok_c[MAX_SEGMENTS].found;
			hit_q   <= tok_c[MAX_SEGMENTS].ent;
			hidx_q  <= idx_c[MAX_SEGMENTS];
			off_q   <= addr_q - tok_c[MAX_SEGMENTS].ent.base;
		end
		if (state_q == S_CALC) begin
			if (!found_q) begin
				res_status_q <= ST_NOT_MAP;
				res_idx_q    <= 4'd0;
				res_ent_q    <= '0;
				res_off_q    <= '0;
				res_len_q    <= '0;
				res_last_q   <= 1'b1;
			end else if (split_q) begin
				res_status_q <= zero_wr ? ST_ZERO_WR : ST_OK;
				res_idx_q    <= 4'(hidx_q);
				res_ent_q    <= hit_q;
				res_off_q    <= off_q;
				res_len_q    <= nn;
				res_last_q   <= zero_wr || (nn == rem_q) || (pieces_q == PW'(MAX_SEGMENTS));
			end else begin
				res_status_q <= ST_OK;
				res_idx_q    <= 4'(hidx_q);
				res_ent_q    <= hit_q;
				res_off_q    <= '0;
				res_len_q    <= '0;
				res_last_q   <= 1'b1;
			end
		end
		if (push && !res_last_q) begin
			addr_q   <= addr_q + 64'(res_len_q);
			rem_q    <= rem_q - res_len_q;
			pieces_q <= pieces_q + PW'(1);
		end
	end

	// Output register: the next item may be accepted while a result waits here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (push) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			m_tdata_q <= {5'd0, 5'(count_q), res_len_q, res_off_q, res_ent_q.kind,
				res_ent_q.backing, res_ent_q.size, res_ent_q.base, res_idx_q};
			m_tuser_q <= res_status_q;
			m_tlast_q <= res_last_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// Search token entering the first cell.
	always_comb begin
		tok_d0      = '0;
		tok_d0.vld  = launch;
		tok_d0.near = near_q;
		tok_d0.addr = addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s0 <= '0;
		end else begin
			tok_s0 <= tok_d0;
		end
	end

	assign tok_c[0] = tok_s0;
	assign idx_c[0] = '0;

	// The row of cells. A remove moves every entry above the gap one cell down.
	for (genvar j = 0; j < MAX_SEGMENTS; j++) begin : g_cell
		cell_ctl_t  ctl;
		seg_entry_t nbr;
		logic       active;

		always_comb begin
			ctl.load  = app_go && (count_q == CW'(j));
			ctl.shift = rm_go && (CMPW'(j) >= CMPW'(in_index)) && (CW'(j + 1) < count_q);
			active    = (CW'(j) < count_q);
		end

		if (j + 1 < MAX_SEGMENTS) begin : g_nbr
			assign nbr = ent_c[j+1];
		end else begin : g_end
			assign nbr = '0;
		end

		smt_cell #(
			.IW       (IW),
			.CELL_IDX (j)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.new_ent (new_ent),
			.nbr_ent (nbr),
			.active  (active),
			.ent     (ent_c[j]),
			.tok_in  (tok_c[j]),
			.idx_in  (idx_c[j]),
			.tok_out (tok_c[j+1]),
			.idx_out (idx_c[j+1])
		);
	end

	// The table never holds more entries than it has cells.
	`SMT_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(MAX_SEGMENTS))
	// A search token only leaves the chain while the sequencer waits for it.
	`SMT_ASSERT_NOW(a_tok_when_wait, tok_c[MAX_SEGMENTS].vld, state_q == S_WAIT)
	// A successful append grows the table by exactly one entry.
	`SMT_ASSERT_NEXT(a_append_count, app_go, count_q == $past(count_q) + CW'(1))
	// Handing over the final result of an item frees the block for the next one.
	`SMT_ASSERT_NEXT(a_last_to_idle, push && res_last_q, state_q == S_IDLE)

endmodule

@@ sv/smt_cell.sv @@
// One cell of the segment table: holds one entry and one stage of the search chain.
// Depends on smt_pkg.
module smt_cell import smt_pkg::*; #(
	parameter int IW       = 4,
	parameter int CELL_IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cell_ctl_t     ctl,
	input  seg_entry_t    new_ent,
	input  seg_entry_t    nbr_ent,
	input  logic          active,
	output seg_entry_t    ent,
	input  search_tok_t   tok_in,
	input  logic [IW-1:0] idx_in,
	output search_tok_t   tok_out,
	output logic [IW-1:0] idx_out
);

	seg_entry_t    ent_q;
	search_tok_t   tok_s1;
	logic [IW-1:0] idx_s1;
	search_tok_t   tok_d;
	logic [IW-1:0] idx_d;
	logic [63:0]   rel;
	logic [63:0]   gap;
	logic          holds;
	logic          above;
	logic          take;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			ent_q <= new_ent;
		end else if (ctl.shift) begin
			ent_q <= nbr_ent;
		end
	end

	// The token walks upwards through the table, so a later take means a newer entry.
	always_comb begin
		rel   = tok_in.addr - ent_q.base;
		gap   = ent_q.base - tok_in.addr;
		holds = active && (tok_in.addr >= ent_q.base) && (rel < ent_q.size);
		above = active && (ent_q.base > tok_in.addr);
		take  = tok_in.near ? (above && (!tok_in.found || gap <= tok_in.gap)) : holds;
		tok_d = tok_in;
		idx_d = idx_in;
		if (take) begin
			tok_d.found = 1'b1;
			tok_d.gap   = gap;
			tok_d.ent   = ent_q;
			idx_d       = IW'(CELL_IDX);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			idx_s1 <= '0;
		end else begin
			tok_s1 <= tok_d;
			idx_s1 <= idx_d;
		end
	end

	assign ent     = ent_q;
	assign tok_out = tok_s1;
	assign idx_out = idx_s1;

endmodule

@@ dv/tb_segment_map_translator_top.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for segment_map_translator_top: table edits, lookups and splits.
// Depends on smt_pkg and the RTL of the segment map translator; needs nothing else.

module tb_segment_map_translator_top import smt_pkg::*;;

	localparam int NSEG = 16;

	// One result of the block, field by field.
	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  index;
		logic [63:0] hbase;
		logic [63:0] hsize;
		logic [63:0] hback;
		logic [1:0]  hkind;
		logic [63:0] poff;
		logic [31:0] plen;
		logic [4:0]  used;
		logic        last;
	} seg_result_t;

	// The scoreboard keeps its own copy of the segment table and the results it still owes.
	class seg_scoreboard;
		logic [63:0] tbl_base[NSEG];
		logic [63:0] tbl_size[NSEG];
		logic [63:0] tbl_back[NSEG];
		logic [1:0]  tbl_kind[NSEG];
		int          used;
		seg_result_t owed[$];
		int          mismatches;
		int          results_seen;

		function new();
			used = 0;
			mismatches = 0;
			results_seen = 0;
		endfunction

		function seg_result_t make_result(logic [2:0] st, int idx, bit with_ent,
				logic [63:0] off, logic [31:0] len);
			seg_result_t r;
			r.status = st;
			r.index  = (idx >= 0) ? idx[3:0] : 4'd0;
			if (with_ent && idx >= 0) begin
				r.hbase = tbl_base[idx];
				r.hsize = tbl_size[idx];
				r.hback = tbl_back[idx];
				r.hkind = tbl_kind[idx];
			end else begin
				r.hbase = '0;
				r.hsize = '0;
				r.hback = '0;
				r.hkind = '0;
			end
			r.poff = off;
			r.plen = len;
			r.used = used[4:0];
			r.last = 1'b0;
			return r;
		endfunction

		// Newest entry holding the address, or -1.
		function int holder_of(logic [63:0] a);
			for (int i = used - 1; i >= 0; i--)
				if (tbl_base[i] <= a && (a - tbl_base[i]) < tbl_size[i])
					return i;
			return -1;
		endfunction

		// Entry with the nearest base strictly above the address; ties go to the newest.
		function int nearest_above(logic [63:0] a);
			int best;
			logic [63:0] bd, d;
			best = -1;
			bd = '0;
			for (int i = used - 1; i >= 0; i--)
				if (tbl_base[i] > a) begin
					d = tbl_base[i] - a;
					if (best < 0 || d < bd) begin
						bd = d;
						best = i;
					end
				end
			return best;
		endfunction

		// Notes an accepted item and queues the results it must cause.
		function void note_item(logic [2:0] op, logic [295:0] d);
			logic [63:0] addr, a, off, room;
			logic [31:0] len, tot, rem, nn;
			logic        wr;
			logic [1:0]  kind;
			int          idx, n;
			seg_result_t batch[$];
			addr = d[63:0];
			len  = d[95:64];
			wr   = d[96];
			case (op)
				OP_APPEND: begin
					if (used >= NSEG)
						batch.push_back(make_result(ST_FULL, 0, 0, '0, '0));
					else begin
						kind = d[290:289];
						tbl_base[used] = d[160:97];
						tbl_size[used] = d[224:161];
						tbl_back[used] = d[288:225];
						tbl_kind[used] = (kind == KIND_RSVD) ? KIND_FILE : kind;
						used++;
						batch.push_back(make_result(ST_OK, used - 1, 0, '0, '0));
					end
				end
				OP_REMOVE: begin
					idx = int'(d[294:291]);
					if (idx >= used)
						batch.push_back(make_result(ST_IGNORED, idx, 0, '0, '0));
					else begin
						for (int j = idx; j + 1 < used; j++) begin
							tbl_base[j] = tbl_base[j + 1];
							tbl_size[j] = tbl_size[j + 1];
							tbl_back[j] = tbl_back[j + 1];
							tbl_kind[j] = tbl_kind[j + 1];
						end
						used--;
						batch.push_back(make_result(ST_OK, idx, 0, '0, '0));
					end
				end
				OP_LOOKUP, OP_NEAREST: begin
					idx = (op == OP_LOOKUP) ? holder_of(addr) : nearest_above(addr);
					if (idx < 0)
						batch.push_back(make_result(ST_NOT_MAP, -1, 0, '0, '0));
					else
						batch.push_back(make_result(ST_OK, idx, 1, '0, '0));
				end
				OP_SPLIT: begin
					tot = '0;
					n = 0;
					if (len == 0) begin
						batch.push_back(make_result(ST_OK, -1, 0, '0, '0));
						n = 1;
					end
					while (tot < len && n < NSEG + 1) begin
						a = addr + {32'd0, tot};
						rem = len - tot;
						idx = holder_of(a);
						if (idx < 0) begin
							batch.push_back(make_result(ST_NOT_MAP, -1, 0, '0, '0));
							break;
						end
						off = a - tbl_base[idx];
						room = tbl_size[idx] - off;
						nn = ({32'd0, rem} > room) ? room[31:0] : rem;
						if (wr && tbl_kind[idx] == KIND_ZERO) begin
							batch.push_back(make_result(ST_ZERO_WR, idx, 1, off, nn));
							break;
						end
						batch.push_back(make_result(ST_OK, idx, 1, off, nn));
						n++;
						tot += nn;
					end
				end
				default: ;
			endcase
			if (batch.size() > 0)
				batch[batch.size() - 1].last = 1'b1;
			foreach (batch[k])
				owed.push_back(batch[k]);
		endfunction

		// Compares one result of the block with the oldest one owed.
		function void check_result(seg_result_t got);
			seg_result_t exp;
			results_seen++;
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d index %0d", got.status,
						got.index);
				return;
			end
			exp = owed.pop_front();
			if (got !== exp) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch: exp st=%0d ix=%0d b=%h s=%h o=%h k=%0d po=%h pl=%h u=%0d l=%b",
						exp.status, exp.index, exp.hbase, exp.hsize, exp.hback, exp.hkind,
						exp.poff, exp.plen, exp.used, exp.last);
					$display("          got st=%0d ix=%0d b=%h s=%h o=%h k=%0d po=%h pl=%h u=%0d l=%b",
						got.status, got.index, got.hbase, got.hsize, got.hback, got.hkind,
						got.poff, got.plen, got.used, got.last);
				end
			end
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [295:0] s_tdata;
	logic [2:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [303:0] m_tdata;
	logic [2:0]   m_tuser;
	logic         m_tlast;

	seg_scoreboard sb;
	int            cycles;
	int            items_sent;
	bit            sink_on;

	segment_map_translator_top #(.MAX_SEGMENTS(NSEG)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Watchdog: generous against the slowest legal run (17 pieces, each result stalled by a
	// long gap, on every item).
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 2000000) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Result side: sample at the rising edge, change tready at the falling edge.
	always @(posedge clk) begin
		seg_result_t r;
		if (arst_n && m_tvalid && m_tready) begin
			r.status = m_tuser;
			r.index  = m_tdata[3:0];
			r.hbase  = m_tdata[67:4];
			r.hsize  = m_tdata[131:68];
			r.hback  = m_tdata[195:132];
			r.hkind  = m_tdata[197:196];
			r.poff   = m_tdata[261:198];
			r.plen   = m_tdata[293:262];
			r.used   = m_tdata[298:294];
			r.last   = m_tlast;
			sb.check_result(r);
		end
	end

	// Gap lengths: mostly short, now and then long.
	function automatic int gap_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(0, 3);
	endfunction

	initial begin
		int g;
		m_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (!sink_on)
				m_tready = 1'b1;
			else if (m_tready && $urandom_range(0, 3) == 0) begin
				m_tready = 1'b0;
				g = gap_len();
				repeat (g) @(negedge clk);
				m_tready = 1'b1;
			end else
				m_tready = 1'b1;
		end
	end

	// Hands one item over and waits for it to be taken; optionally idles first.
	task automatic send_item(input logic [2:0] op, input logic [63:0] addr,
			input logic [31:0] len, input logic wr, input logic [63:0] eb,
			input logic [63:0] es, input logic [63:0] eo, input logic [1:0] ek,
			input logic [3:0] ei, input bit idle);
		int g;
		if (idle) begin
			g = gap_len();
			if (g > 0) begin
				s_tvalid <= 1'b0;
				repeat (g) @(negedge clk);
			end
		end
		s_tuser  <= op;
		s_tdata  <= {1'b0, ei, ek, eo, es, eb, wr, len, addr};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_item(op, {1'b0, ei, ek, eo, es, eb, wr, len, addr});
		items_sent++;
		@(negedge clk);
	endtask

	task automatic append_seg(input logic [63:0] b, input logic [63:0] s,
			input logic [63:0] o, input logic [1:0] k);
		send_item(OP_APPEND, '0, '0, 1'b0, b, s, o, k, '0, 1'b0);
	endtask

	task automatic ask(input logic [2:0] op, input logic [63:0] a, input logic [31:0] len,
			input logic wr, input logic [3:0] ei);
		send_item(op, a, len, wr, '0, '0, '0, '0, ei, 1'b0);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.owed.size() != 0)
			@(negedge clk);
	endtask

	// Random item; segments live in a small window so lookups and splits hit often.
	task automatic random_item();
		logic [2:0]  op;
		logic [63:0] a, b, s;
		logic [31:0] len;
		int          pick;
		pick = $urandom_range(0, 99);
		a = {$urandom, $urandom};
		if ($urandom_range(0, 4) != 0)
			a = 64'h1000 + 64'($urandom_range(0, 4095));
		len = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 1200);
		if (pick < 5)
			op = 3'(5 + $urandom_range(0, 2));
		else if (pick < 30)
			op = OP_APPEND;
		else if (pick < 45)
			op = OP_REMOVE;
		else if (pick < 60)
			op = OP_LOOKUP;
		else if (pick < 70)
			op = OP_NEAREST;
		else
			op = OP_SPLIT;
		b = 64'h1000 + 64'($urandom_range(0, 4000));
		s = 64'($urandom_range(1, 600));
		if ($urandom_range(0, 9) == 0) begin
			b = {$urandom, $urandom};
			s = {$urandom, $urandom};
		end
		send_item(op, a, len, 1'($urandom_range(0, 1)), b, s, {$urandom, $urandom},
			2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), 1'b1);
		if (op > OP_SPLIT)
			items_sent--;
	endtask

	initial begin
		sb = new();
		cycles = 0;
		items_sent = 0;
		sink_on = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_APPEND;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: misses on an empty table, an empty transfer and an ignored remove.
		ask(OP_LOOKUP, 64'h0, '0, 1'b0, '0);
		ask(OP_NEAREST, '1, '0, 1'b0, '0);
		ask(OP_SPLIT, 64'h10, 32'd0, 1'b0, '0);
		ask(OP_REMOVE, '0, '0, 1'b0, 4'd15);
		// Overlapping segments, a reserved kind, a zero segment and one at the top.
		append_seg(64'h1000, 64'h100, 64'hAAAA, KIND_FILE);
		append_seg(64'h1080, 64'h100, 64'hBBBB, KIND_RSVD);
		append_seg(64'h1180, 64'h80, 64'hCCCC, KIND_ZERO);
		append_seg(64'hFFFF_FFFF_FFFF_FF00, 64'h100, '1, 2'd1);
		append_seg(64'h0, 64'h40, '0, KIND_FILE);
		append_seg(64'h1000, 64'h10, 64'h1, 2'd1);
		ask(OP_LOOKUP, 64'h1090, '0, 1'b0, '0);
		ask(OP_NEAREST, 64'h1000, '0, 1'b0, '0);
		ask(OP_SPLIT, 64'h1000, 32'h300, 1'b0, '0);
		ask(OP_SPLIT, 64'h1100, 32'h100, 1'b1, '0);
		// Wrap past the top of the address space into the segment at zero.
		ask(OP_SPLIT, 64'hFFFF_FFFF_FFFF_FFF0, 32'h30, 1'b1, '0);
		ask(OP_SPLIT, 64'h5000, '1, 1'b0, '0);
		ask(OP_REMOVE, '0, '0, 1'b0, 4'd1);
		ask(3'd7, '0, '0, 1'b0, '0);
		// Fill the table to the limit and one beyond.
		for (int i = 0; i < 12; i++)
			append_seg(64'h2000 + 64'(i) * 64'h10, 64'h10, 64'(i), 2'd1);
		ask(OP_SPLIT, 64'h2000, 32'hB0, 1'b0, '0);
		drain();
		sink_on = 1'b1;

		while (items_sent < 180) begin
			random_item();
			// When the item count reaches 120, pause until every owed result is back.
			if (items_sent == 120)
				drain();
		end
		drain();
		repeat (60) @(negedge clk);

		$display("Covered %0d items and %0d results: appends up to a full table,", items_sent,
			sb.results_seen);
		$display("removes, lookups, nearest searches, split transfers and unknown codes.");
		if (sb.mismatches == 0 && sb.owed.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+sv
sv/smt_pkg.sv
sv/smt_cell.sv
sv/segment_map_translator_top.sv
dv/tb_segment_map_translator_top.sv
